>>> rtl/swso_pkg.sv
// Package: entry type, function codes and controller state/command types.
package swso_pkg;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] priority_v;
        logic [15:0] weight;
        logic        is_ipv6;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_SORT = 2'd1,
        FUNC_DRAW = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_MOD,
        S_WALK_RD,
        S_WALK_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;    // latch request
        logic wr_load;    // write request entry at count
        logic idx_clr;
        logic idx_inc;
        logic rd_pair;    // read idx and idx+1
        logic wr_a;       // swap write, first half
        logic wr_b;       // swap write, second half
        logic sum_clr;
        logic sum_acc;
        logic mod_start;
        logic mod_step;
        logic sel_sub;
        logic pick;       // capture drawn entry
        logic shift_wr;   // store[idx] <= store[idx+1]
        logic cnt_dec;
        logic out_set;
        logic out_empty;
    } t_cmd;

    typedef struct packed {
        logic func_load;
        logic func_sort;
        logic func_draw;
        logic full;
        logic empty;
        logic pair_end;   // idx+1 >= count
        logic idx_end;    // idx >= count
        logic swap;
        logic same_pri;
        logic mod_done;
        logic sel_hit;
        logic out_busy;
    } t_sts;

endpackage

>>> rtl/swso_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module swso_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_a,
    output logic [Width-1:0]         o_rdata_b
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

>>> rtl/swso_ctrl.sv
// Controller state machine for load, sort and draw sequencing.
module swso_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  swso_pkg::t_sts i_sts,
    output logic           o_stall,
    output swso_pkg::t_cmd o_cmd
);
    import swso_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.func_load) n_state = S_IDLE;
                else if (i_sts.func_sort) n_state = S_SORT_RD;
                else if (i_sts.func_draw) begin
                    n_state = i_sts.empty ? S_OUT : S_SUM_RD;
                end else n_state = S_IDLE;
            end
            S_SORT_RD:  n_state = i_sts.pair_end ? S_IDLE : S_SORT_CMP;
            S_SORT_CMP: n_state = i_sts.swap ? S_SORT_WR : S_SORT_RD;
            S_SORT_WR:  n_state = S_SORT_RD;
            S_SUM_RD:   n_state = i_sts.idx_end ? S_MOD : S_SUM_ACC;
            S_SUM_ACC:  n_state = i_sts.same_pri ? S_SUM_RD : S_MOD;
            S_MOD:      n_state = i_sts.mod_done ? S_WALK_RD : S_MOD;
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: n_state = i_sts.sel_hit ? S_SHIFT_RD : S_WALK_RD;
            S_SHIFT_RD: n_state = i_sts.pair_end ? S_OUT : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_OUT:      n_state = i_sts.out_busy ? S_OUT : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: o_cmd.load_in = i_valid;
            S_LOAD: begin
                o_cmd.idx_clr = 1'b1;
                o_cmd.sum_clr = 1'b1;
                o_cmd.wr_load = i_sts.func_load && !i_sts.full;
            end
            S_SORT_RD:  o_cmd.rd_pair = 1'b1;
            S_SORT_CMP: begin
                o_cmd.wr_a    = i_sts.swap;
                o_cmd.idx_inc = !i_sts.swap;
            end
            S_SORT_WR: begin
                o_cmd.wr_b    = 1'b1;
                o_cmd.idx_clr = 1'b1;
            end
            S_SUM_RD: begin
                o_cmd.rd_pair   = 1'b1;
                o_cmd.mod_start = i_sts.idx_end;
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc   = i_sts.same_pri;
                o_cmd.idx_inc   = i_sts.same_pri;
                o_cmd.mod_start = !i_sts.same_pri;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.idx_clr  = i_sts.mod_done;
            end
            S_WALK_RD:  o_cmd.rd_pair = 1'b1;
            S_WALK_CHK: begin
                o_cmd.pick    = i_sts.sel_hit;
                o_cmd.sel_sub = !i_sts.sel_hit;
                o_cmd.idx_inc = !i_sts.sel_hit;
            end
            S_SHIFT_RD: begin
                o_cmd.rd_pair = 1'b1;
                o_cmd.cnt_dec = i_sts.pair_end;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_set   = !i_sts.out_busy;
                o_cmd.out_empty = !i_sts.out_busy && i_sts.empty;
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/swso_dp.sv
// Datapath: entry store, count, sort compare, weight sum, modulo, output register.
module swso_dp #(
    parameter int MaxEntries = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swso_pkg::t_cmd i_cmd,
    output swso_pkg::t_sts o_sts,
    input  logic           i_prefer_ipv6,
    input  logic [1:0]     i_func,
    input  logic           i_is_ipv6,
    input  logic [15:0]    i_priority_req,
    input  logic [15:0]    i_weight,
    input  logic [7:0]     i_tag,
    input  logic [30:0]    i_random_value,
    input  logic           i_out_stall,
    output logic           o_valid,
    output logic           o_valid_res,
    output logic [7:0]     o_out_tag,
    output logic [15:0]    o_out_priority,
    output logic [15:0]    o_out_weight,
    output logic           o_out_is_ipv6,
    output logic           o_last
);
    import swso_pkg::*;

    localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CW = $clog2(MaxEntries + 1);
    localparam int SW = 17 + CW;   // sum of up to MaxEntries (weight+1)
    localparam int MW = 32;        // width for modulo/select values

    logic [1:0]  r_func;
    t_entry      r_in;
    logic [30:0] r_rnd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_sum;
    logic [MW-1:0] r_rem, r_den;
    logic [5:0]    r_bit;
    logic          r_mod_busy;
    logic [MW-1:0] r_sel;
    t_entry        r_pick;

    t_entry rd_a, rd_b, lead_e;
    logic   ram_we;
    logic [AW-1:0] waddr, ra, rb;
    t_entry wdata;
    logic [CW-1:0] idx1;

    assign idx1 = r_idx + CW'(1);
    assign ra   = r_idx[AW-1:0];
    assign rb   = i_cmd.rd_pair ? idx1[AW-1:0] : AW'(0);

    always_comb begin
        ram_we = 1'b0;
        waddr  = ra;
        wdata  = rd_a;
        if (i_cmd.wr_load) begin
            ram_we = 1'b1; waddr = r_cnt[AW-1:0]; wdata = r_in;
        end else if (i_cmd.wr_a) begin
            ram_we = 1'b1; waddr = ra; wdata = rd_b;
        end else if (i_cmd.wr_b) begin
            ram_we = 1'b1; waddr = idx1[AW-1:0]; wdata = r_pick;
        end else if (i_cmd.shift_wr) begin
            ram_we = 1'b1; waddr = ra; wdata = rd_b;
        end
    end

    logic [EntryW-1:0] qa, qb;
    swso_ram #(.Width(EntryW), .Depth(1 << AW)) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(ra),
        .i_raddr_b(rb),
        .o_rdata_a(qa),
        .o_rdata_b(qb)
    );
    assign rd_a = t_entry'(qa);
    assign rd_b = t_entry'(qb);

    // set once this draw picked an entry, so a store emptied by it is not an empty draw
    logic          r_picked;
    logic          swap;
    logic [MW-1:0] w1;
    assign lead_e = rd_a;
    assign w1 = MW'(rd_a.weight) + MW'(1);

    always_comb begin
        if (i_prefer_ipv6 && rd_a.is_ipv6 && !rd_b.is_ipv6) swap = 1'b0;
        else if (rd_a.priority_v < rd_b.priority_v) swap = 1'b0;
        else if (rd_a.priority_v == rd_b.priority_v &&
                 (rd_a.weight == 16'd0 || rd_b.weight != 16'd0)) swap = 1'b0;
        else swap = 1'b1;
    end

    logic [MW:0] trial;
    assign trial = {r_rem[MW-1:0], r_rnd[r_bit[4:0]]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_mod_busy <= 1'b0;
            o_valid    <= 1'b0;
            r_picked   <= 1'b0;
        end else begin
            if (i_cmd.wr_load) r_cnt <= r_cnt + CW'(1);
            if (i_cmd.cnt_dec) r_cnt <= r_cnt - CW'(1);
            if (i_cmd.mod_start) r_mod_busy <= 1'b1;
            else if (i_cmd.mod_step && r_bit == 6'd0) r_mod_busy <= 1'b0;
            if (i_cmd.out_set) o_valid <= 1'b1;
            else if (!i_out_stall) o_valid <= 1'b0;
            if (i_cmd.pick) r_picked <= 1'b1;
            else if (i_cmd.out_set) r_picked <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_in   <= '{tag: i_tag, priority_v: i_priority_req,
                        weight: i_weight, is_ipv6: i_is_ipv6};
            r_rnd  <= i_random_value;
        end
        if (i_cmd.idx_clr) r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
        if (i_cmd.sum_clr) r_sum <= '0;
        else if (i_cmd.sum_acc) r_sum <= r_sum + SW'(w1);
        if (i_cmd.wr_a) r_pick <= rd_a;   // hold first half of swap
        if (i_cmd.mod_start) begin
            r_den <= MW'(r_sum) + (i_cmd.sum_acc ? w1 : MW'(0));
            r_rem <= '0;
            r_bit <= 6'd30;
        end else if (i_cmd.mod_step && r_mod_busy) begin
            r_rem <= trial[MW] ? {r_rem[MW-2:0], r_rnd[r_bit[4:0]]} : trial[MW-1:0];
            if (r_bit != 6'd0) r_bit <= r_bit - 6'd1;
        end
        if (i_cmd.mod_step && !r_mod_busy) r_sel <= r_rem + MW'(1);
        else if (i_cmd.sel_sub) r_sel <= r_sel - w1;
        if (i_cmd.pick) r_pick <= rd_a;
        if (i_cmd.out_set) begin
            o_valid_res    <= !i_cmd.out_empty;
            o_out_tag      <= i_cmd.out_empty ? '0 : r_pick.tag;
            o_out_priority <= i_cmd.out_empty ? '0 : r_pick.priority_v;
            o_out_weight   <= i_cmd.out_empty ? '0 : r_pick.weight;
            o_out_is_ipv6  <= i_cmd.out_empty ? 1'b0 : r_pick.is_ipv6;
            o_last         <= !i_cmd.out_empty && (r_cnt == '0);
        end
    end

    // group lead priority: entry 0 read in the first sum step
    logic [15:0] lead_pri;
    logic        r_lead_ok;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) r_lead_ok <= 1'b0;
        else if (i_cmd.sum_acc) r_lead_ok <= 1'b1;
    end
    logic [15:0] r_lead_pri;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_acc && !r_lead_ok) r_lead_pri <= lead_e.priority_v;
    end
    assign lead_pri = r_lead_ok ? r_lead_pri : lead_e.priority_v;

    assign o_sts.func_load = (r_func == FUNC_LOAD);
    assign o_sts.func_sort = (r_func == FUNC_SORT);
    assign o_sts.func_draw = (r_func == FUNC_DRAW);
    assign o_sts.full      = (r_cnt >= CW'(MaxEntries));
    assign o_sts.empty     = (r_cnt == '0) && !r_picked;
    assign o_sts.pair_end  = (idx1 >= r_cnt);
    assign o_sts.idx_end   = (r_idx >= r_cnt);
    assign o_sts.swap      = swap;
    assign o_sts.same_pri  = (rd_a.priority_v == lead_pri);
    assign o_sts.mod_done  = !r_mod_busy;
    assign o_sts.sel_hit   = (r_sel <= w1) || (idx1 >= r_cnt);
    assign o_sts.out_busy  = o_valid && i_out_stall;
endmodule

>>> rtl/srv_weighted_server_order.sv
// Top level: weighted SRV server ordering block.
// Sequencing: load writes one entry; sort compares adjacent pairs, writing a swap where
// needed and restarting after each swap; draw sums weight+1 over the entries sharing
// entry 0's priority, runs a bit-serial modulo, walks to the pick, closes up the entries
// behind it, then fills the result register. One request in flight at a time.
// Reset (synchronous, active low) empties the store and sets prefer_ipv6 to 1.
module srv_weighted_server_order #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic        i_is_ipv6,
    input  logic [15:0] i_priority_req,
    input  logic [15:0] i_weight,
    input  logic [7:0]  i_tag,
    input  logic [30:0] i_random_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [7:0]  o_out_tag,
    output logic [15:0] o_out_priority,
    output logic [15:0] o_out_weight,
    output logic        o_out_is_ipv6,
    output logic        o_last
);
    import swso_pkg::*;

    logic r_prefer_ipv6;
    t_cmd cmd;
    t_sts sts;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefer_ipv6 <= 1'b1;
        end else if (i_cfg_we) begin
            r_prefer_ipv6 <= i_cfg_wdata;
        end
    end

    swso_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_sts  (sts),
        .o_stall(o_stall),
        .o_cmd  (cmd)
    );

    swso_dp #(.MaxEntries(MAX_ENTRIES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_prefer_ipv6 (r_prefer_ipv6),
        .i_func        (i_func),
        .i_is_ipv6     (i_is_ipv6),
        .i_priority_req(i_priority_req),
        .i_weight      (i_weight),
        .i_tag         (i_tag),
        .i_random_value(i_random_value),
        .i_out_stall   (i_stall),
        .o_valid       (o_valid),
        .o_valid_res   (o_valid_res),
        .o_out_tag     (o_out_tag),
        .o_out_priority(o_out_priority),
        .o_out_weight  (o_out_weight),
        .o_out_is_ipv6 (o_out_is_ipv6),
        .o_last        (o_last)
    );
endmodule
